// ===== design/rgbd_pkg.sv =====
// shared types, constants and table builders for the rgb332 dither codec
`default_nettype none

package rgbd_pkg;

  // command codes
  localparam logic [1:0] CMD_DITHER = 2'd0;
  localparam logic [1:0] CMD_PLAIN  = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam int CHAN_W   = 13;
  localparam int COORD_W  = 12;
  localparam int AMT_W    = 9;
  localparam int TBL_W    = 17;  // signed table entry, enough for 16 fraction bits
  localparam logic [AMT_W-1:0] AMT_RESET = 9'd128;

  // red/green numerators over 110, row-major by {y[1:0], x[1:0]}
  localparam int DITH_NUM [16] = '{
    -16,   4,  13,  -1,
      8, -12,  -5,   9,
    -14,   2,  15,  -3,
      6, -10,  -7,  11
  };

  typedef logic signed [TBL_W-1:0] rgbd_tbl_t [16];
  typedef logic [CHAN_W-1:0] rgbd_dec_tbl_t [8];

  typedef struct packed {
    logic [1:0]         command;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         packed_in;
  } rgbd_in_t;

  typedef struct packed {
    logic [7:0]        packed_out;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } rgbd_out_t;

  // red/green offsets: round(k * one / 110)
  function automatic rgbd_tbl_t rg_table(int fb);
    rgbd_tbl_t t;
    longint    mag;
    longint    r;
    for (int i = 0; i < 16; i++) begin
      mag = (DITH_NUM[i] < 0) ? -longint'(DITH_NUM[i]) : longint'(DITH_NUM[i]);
      r = (mag * (longint'(1) << (fb + 1)) + 110) / 220;
      t[i] = (DITH_NUM[i] < 0) ? TBL_W'(-r) : TBL_W'(r);
    end
    return t;
  endfunction

  // blue offsets: round(-k * one / 50)
  function automatic rgbd_tbl_t b_table(int fb);
    rgbd_tbl_t t;
    longint    mag;
    longint    r;
    for (int i = 0; i < 16; i++) begin
      mag = (DITH_NUM[i] < 0) ? -longint'(DITH_NUM[i]) : longint'(DITH_NUM[i]);
      r = (mag * (longint'(1) << (fb + 1)) + 50) / 100;
      t[i] = (DITH_NUM[i] > 0) ? TBL_W'(-r) : TBL_W'(r);
    end
    return t;
  endfunction

  // 3-bit code to fixed point, round(code * one / 7), kept to 13 bits
  function automatic rgbd_dec_tbl_t rg_dec_table(int fb);
    rgbd_dec_tbl_t t;
    longint        r;
    for (int i = 0; i < 8; i++) begin
      r = (longint'(i) * (longint'(1) << (fb + 1)) + 7) / 14;
      t[i] = CHAN_W'(r);
    end
    return t;
  endfunction

  // 2-bit code to fixed point, round(code * one / 3); upper entries unused
  function automatic rgbd_dec_tbl_t b_dec_table(int fb);
    rgbd_dec_tbl_t t;
    longint        r;
    for (int i = 0; i < 8; i++) begin
      r = (longint'(i) * (longint'(1) << (fb + 1)) + 3) / 6;
      t[i] = CHAN_W'(r);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== design/rgbd_dp.sv =====
// three-stage encode/decode datapath of the rgb332 dither codec
`default_nettype none

module rgbd_dp #(
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire rgbd_pkg::rgbd_in_t           in_data,
  input  wire logic [rgbd_pkg::AMT_W-1:0]   amt,
  output logic                              out_valid,
  output rgbd_pkg::rgbd_out_t               out_data
);

  localparam int CW    = rgbd_pkg::CHAN_W;
  localparam int OW    = rgbd_pkg::TBL_W + rgbd_pkg::AMT_W + 1;  // offset product
  localparam int VW    = OW + 1;                                 // dithered value
  localparam int SHIFT = FRACTION_BITS + 8;

  localparam rgbd_pkg::rgbd_tbl_t     RG_TBL  = rgbd_pkg::rg_table(FRACTION_BITS);
  localparam rgbd_pkg::rgbd_tbl_t     B_TBL   = rgbd_pkg::b_table(FRACTION_BITS);
  localparam rgbd_pkg::rgbd_dec_tbl_t RG_DEC  = rgbd_pkg::rg_dec_table(FRACTION_BITS);
  localparam rgbd_pkg::rgbd_dec_tbl_t B_DEC   = rgbd_pkg::b_dec_table(FRACTION_BITS);

  // times mult, truncate, clamp; non-positive values give zero
  function automatic logic [2:0] quant(logic signed [VW-1:0] v, logic [2:0] mult);
    logic [VW+2:0] p;
    logic [VW+2:0] q;
    p = (VW+3)'(v[VW-2:0]) * (VW+3)'(mult);
    q = p >> SHIFT;
    if (v[VW-1] || (v == '0)) begin
      return 3'd0;
    end else if (q > (VW+3)'(mult)) begin
      return mult;
    end else begin
      return q[2:0];
    end
  endfunction

  // stage 1: table lookup and offset multiply, decode lookup
  localparam int AMT_W_S = rgbd_pkg::AMT_W;

  logic                 s1_valid_r;
  logic [1:0]           s1_cmd_r;
  logic [CW-1:0]        s1_red_r, s1_green_r, s1_blue_r;
  logic signed [OW-1:0] s1_off_rg_r, s1_off_b_r;
  logic [CW-1:0]        s1_dr_r, s1_dg_r, s1_db_r;

  logic [3:0]           idx;
  logic signed [OW-1:0] off_rg_nxt, off_b_nxt;
  logic signed [AMT_W_S:0] amt_s;

  assign idx   = {in_data.pixel_y[1:0], in_data.pixel_x[1:0]};
  assign amt_s = $signed({1'b0, amt});

  always_comb begin
    if (in_data.command == rgbd_pkg::CMD_DITHER) begin
      off_rg_nxt = OW'(RG_TBL[idx] * amt_s);
      off_b_nxt  = OW'(B_TBL[idx] * amt_s);
    end else begin
      off_rg_nxt = '0;
      off_b_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_cmd_r    <= in_data.command;
      s1_red_r    <= in_data.red;
      s1_green_r  <= in_data.green;
      s1_blue_r   <= in_data.blue;
      s1_off_rg_r <= off_rg_nxt;
      s1_off_b_r  <= off_b_nxt;
      s1_dr_r     <= RG_DEC[in_data.packed_in[7:5]];
      s1_dg_r     <= RG_DEC[in_data.packed_in[4:2]];
      s1_db_r     <= B_DEC[{1'b0, in_data.packed_in[1:0]}];
    end
  end

  // stage 2: subtract offsets from the scaled channels
  logic                 s2_valid_r;
  logic [1:0]           s2_cmd_r;
  logic signed [VW-1:0] s2_rv_r, s2_gv_r, s2_bv_r;
  logic [CW-1:0]        s2_dr_r, s2_dg_r, s2_db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_cmd_r <= s1_cmd_r;
      s2_rv_r  <= $signed(VW'({s1_red_r, 8'b0}))   - VW'(s1_off_rg_r);
      s2_gv_r  <= $signed(VW'({s1_green_r, 8'b0})) - VW'(s1_off_rg_r);
      s2_bv_r  <= $signed(VW'({s1_blue_r, 8'b0}))  - VW'(s1_off_b_r);
      s2_dr_r  <= s1_dr_r;
      s2_dg_r  <= s1_dg_r;
      s2_db_r  <= s1_db_r;
    end
  end

  // stage 3: quantize, pack and select the result
  logic                out_valid_r;
  rgbd_pkg::rgbd_out_t out_data_r;
  rgbd_pkg::rgbd_out_t out_nxt;
  logic [2:0]          rc_q, gc_q, bc_q;

  assign rc_q = quant(s2_rv_r, 3'd7);
  assign gc_q = quant(s2_gv_r, 3'd7);
  assign bc_q = quant(s2_bv_r, 3'd3);

  always_comb begin
    out_nxt = '0;
    unique case (s2_cmd_r)
      rgbd_pkg::CMD_DITHER, rgbd_pkg::CMD_PLAIN: begin
        out_nxt.packed_out = {rc_q, gc_q, bc_q[1:0]};
      end
      rgbd_pkg::CMD_DECODE: begin
        out_nxt.red_out   = s2_dr_r;
        out_nxt.green_out = s2_dg_r;
        out_nxt.blue_out  = s2_db_r;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== design/rgb332_ordered_dither_codec.sv =====
// top level of the rgb332 ordered-dither codec
//
//  channel  ports                          transaction when
//  -------  -----------------------------  ----------------------------------
//  input    start, busy, in_data           start high and busy low at clk
//  result   out_valid, out_data            out_valid high at clk
//  config   cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high at clk
//
// one pixel per clock; each transaction passes through the three register
// stages of rgbd_dp (lookup and offset multiply, subtract, quantize and pack)
// before its result appears. busy never rises and cfg_ready stays high.
// rst_n is synchronous and active low: it empties the pipeline and sets the
// dither amount to 128. the receiver cannot stall, so results just flow out.
`default_nettype none

module rgb332_ordered_dither_codec #(
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire rgbd_pkg::rgbd_in_t          in_data,
  // result channel
  output logic                             out_valid,
  output rgbd_pkg::rgbd_out_t              out_data,
  // config channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rgbd_pkg::AMT_W-1:0]  cfg_data
);

  // dither strength register, q1.8
  logic [rgbd_pkg::AMT_W-1:0] amt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amt_r <= rgbd_pkg::AMT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      amt_r <= cfg_data;
    end
  end

  // fully pipelined: never holds off either side
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  rgbd_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .amt       (amt_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/rgbd_chk.sv =====
// port-level checker for the rgb332 dither codec, with its bind
`default_nettype none

module rgbd_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire rgbd_pkg::rgbd_in_t          in_data,
  input wire logic                        out_valid,
  input wire rgbd_pkg::rgbd_out_t         out_data
);

  // every accepted transaction comes out as a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // no result without a matching accepted transaction before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching transaction");

  // an encoded byte never comes with decoded channels
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.packed_out != 8'd0)) |->
      (out_data.red_out == '0) && (out_data.green_out == '0) &&
      (out_data.blue_out == '0))
    else $error("encode and decode fields both nonzero");

  // a decode transaction never produces a packed byte
  a_decode_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command == rgbd_pkg::CMD_DECODE)) |->
      ##3 (out_data.packed_out == 8'd0))
    else $error("decode transaction produced a packed byte");

endmodule

bind rgb332_ordered_dither_codec rgbd_chk u_rgbd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
